/* hw/rtl/btd_gf64_pkg.sv */
// package with gf(2^64) constants and carry-less multiply helpers for the triple dealer
`timescale 1ns / 1ps

package btd_gf64_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned ProdW = 2 * WordW;
    localparam int unsigned PolyW = 5;

    localparam int unsigned FoldW = WordW + PolyW - 1;
    localparam int unsigned SpillW = PolyW - 1;
    localparam int unsigned SpillFoldW = SpillW + PolyW - 1;

    // low part of x^64 + x^4 + x^3 + x + 1
    localparam logic [PolyW-1:0] GfPolyLow = PolyW'((1 << 4) | (1 << 3) | (1 << 1) | 1);

    typedef logic [WordW-1:0] t_word;
    typedef logic [ProdW-1:0] t_prod;

    function automatic t_prod clmul_word(input t_word x, input t_word y);
        t_prod acc;
        acc = '0;
        for (int i = 0; i < WordW; i++) begin
            if (y[i]) begin
                acc = acc ^ (t_prod'(x) << i);
            end
        end
        return acc;
    endfunction

    function automatic logic [FoldW-1:0] fold_high(input t_word h);
        logic [FoldW-1:0] acc;
        acc = '0;
        for (int i = 0; i < PolyW; i++) begin
            if (GfPolyLow[i]) begin
                acc = acc ^ (FoldW'(h) << i);
            end
        end
        return acc;
    endfunction

    function automatic logic [SpillFoldW-1:0] fold_spill(input logic [SpillW-1:0] h);
        logic [SpillFoldW-1:0] acc;
        acc = '0;
        for (int i = 0; i < PolyW; i++) begin
            if (GfPolyLow[i]) begin
                acc = acc ^ (SpillFoldW'(h) << i);
            end
        end
        return acc;
    endfunction

    function automatic t_word gf64_reduce(input t_prod p);
        logic [FoldW-1:0]      f1;
        logic [SpillFoldW-1:0] f2;
        f1 = fold_high(p[ProdW-1:WordW]);
        f2 = fold_spill(f1[FoldW-1:WordW]);
        return p[WordW-1:0] ^ f1[WordW-1:0] ^ WordW'(f2);
    endfunction

endpackage

/* hw/rtl/beaver_triple_dealer_gf64.sv */
// beaver triple dealer over gf(2^64): share accumulation, field multiply and result register
`timescale 1ns / 1ps

// Takes one party share beat per cycle while the input is not stalled. The a, b and c
// shares of a bin are XOR-summed into running registers; the beat flagged last_party folds
// in its own a and b, drops its c, and latches the bin totals into a stage register. Once
// the output can load, a combinational carry-less 64x64 multiply and reduction by
// x^64+x^4+x^3+x+1 produce the final party's c share into the result register, so a
// result passes through the stage register and then the result register before it shows
// on the output. Sustained rate is one beat per cycle; the input stalls only while the stage
// register holds a bin and the result register is held by a stalled output.
module beaver_triple_dealer_gf64 (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  btd_gf64_pkg::t_word       i_share_a,
    input  btd_gf64_pkg::t_word       i_share_b,
    input  btd_gf64_pkg::t_word       i_share_c,
    input  logic                      i_last_party,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output btd_gf64_pkg::t_word       o_final_c_share
);
    import btd_gf64_pkg::*;

    t_word r_sum_a, r_sum_b, r_sum_c;
    t_word n_sum_a, n_sum_b, n_sum_c;
    logic  r_s1_valid, n_s1_valid;
    t_word r_s1_a, r_s1_b, r_s1_c;
    logic  r_out_valid, n_out_valid;
    t_word r_final_c_share;

    logic  in_acc;
    logic  out_load;
    logic  s1_adv;
    t_word tot_a, tot_b;
    t_prod prod;
    t_word result;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_load;
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign tot_a = r_sum_a ^ i_share_a;
    assign tot_b = r_sum_b ^ i_share_b;

    assign prod   = clmul_word(r_s1_a, r_s1_b);
    assign result = gf64_reduce(prod) ^ r_s1_c;

    always_comb begin
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_sum_c     = r_sum_c;
        n_s1_valid  = r_s1_valid && !s1_adv;
        n_out_valid = r_out_valid && i_out_stall;
        if (in_acc) begin
            if (i_last_party) begin
                n_sum_a    = '0;
                n_sum_b    = '0;
                n_sum_c    = '0;
                n_s1_valid = 1'b1;
            end else begin
                n_sum_a = tot_a;
                n_sum_b = tot_b;
                n_sum_c = r_sum_c ^ i_share_c;
            end
        end
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a     <= '0;
            r_sum_b     <= '0;
            r_sum_c     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum_a     <= n_sum_a;
            r_sum_b     <= n_sum_b;
            r_sum_c     <= n_sum_c;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_party) begin
            r_s1_a <= tot_a;
            r_s1_b <= tot_b;
            r_s1_c <= r_sum_c;
        end
        if (s1_adv) begin
            r_final_c_share <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_final_c_share = r_final_c_share;

    // sums restart after the last beat of a bin
    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_party |=> r_sum_a == '0 && r_sum_b == '0 && r_sum_c == '0)
        else $error("sums not cleared after last beat");

    // last beat always lands in the stage register
    a_stage_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_party |=> r_s1_valid)
        else $error("stage register missed a bin");

    // a bin leaving the stage register shows on the output next cycle
    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("result lost between stage and output");

    // a held bin blocks input only while the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall)
        else $error("input stalled without cause");

endmodule
